/* rtl/imd_pkg.sv */
package imd_pkg;

  localparam int DEF_MAX_BINS = 4096;

  localparam int PWR_W   = 32;   // one bin
  localparam int SUM_W   = 39;   // lobe sum
  localparam int BIN_W   = 12;   // reported bin index
  localparam int LHW_W   = 6;    // lobe_half_width
  localparam int GUARD_W = 8;    // guard_bins
  localparam int FFT_W   = 14;   // fft_length
  localparam int FOLD_W  = 13;   // folded bin, at most fft_length/2
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = FFT_W;
  localparam int OUT_DW  = 256;

  localparam logic [CFG_AW-1:0] REG_LOBE_HW = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GUARD   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_FFT_LEN = 2'd2;

  localparam logic [LHW_W-1:0]   RST_LOBE_HW = 6'd4;
  localparam logic [GUARD_W-1:0] RST_GUARD   = 8'd16;
  localparam logic [FFT_W-1:0]   RST_FFT_LEN = 14'd4096;

  localparam logic [BIN_W-1:0] BIN_MAX = 12'hFFF;

  typedef struct packed {
    logic              done;
    logic [FOLD_W-1:0] value;
  } fold_res_t;

endpackage

/* rtl/two_tone_imd_spectrum_analyzer.sv */
// Two-tone intermodulation analyzer. Stream in a one-sided power spectrum, one bin per
// transaction with tlast on the final bin; up to MAX_BINS bins are stored, later ones are
// dropped. After the final bin the block is busy (in_tready low) while it runs, all through
// one RAM read port: a peak search over bins guard+1..n-1, a second search of the same
// range excluding the guard zone around the first peak, then for each of the five lobes
// (two tones, 2*low-high, 2*high-low, high-low) a bit-serial fold modulo fft_length
// followed by a lobe sum over up to 2*lobe_half_width+1 stored bins around the folded bin.
// One result transaction follows; tuser=0 marks a spectrum without two tones, with all
// tdata fields zero. The result sits in an output register, so loading of the next
// spectrum starts as soon as analysis ends, unless the previous result is still waiting.
module two_tone_imd_spectrum_analyzer
  import imd_pkg::*;
#(
  parameter int MAX_BINS = DEF_MAX_BINS
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  // spectrum in
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [PWR_W-1:0]  in_tdata,   // [31:0] bin_power
  input  logic              in_tlast,   // last_bin
  // result out
  output logic              out_tvalid,
  input  logic              out_tready,
  // [11:0] tone_low_bin, [23:12] tone_high_bin, [62:24] tone_low_power,
  // [101:63] tone_high_power, [113:102] im3_low_bin, [152:114] im3_low_power,
  // [164:153] im3_high_bin, [203:165] im3_high_power, [215:204] im2_bin,
  // [254:216] im2_power, [255] zero
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tuser   // result_valid
);

  localparam int AW = $clog2(MAX_BINS);
  localparam int CW = $clog2(MAX_BINS + 1);
  localparam int KW = (CW > FOLD_W) ? CW : FOLD_W;
  localparam int MW = AW + 1;
  localparam int NLOBE = 5;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_PEAK1 = 6'b000010,
    S_PEAK2 = 6'b000100,
    S_FOLD  = 6'b001000,
    S_LOBE  = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [LHW_W-1:0]    lobe_hw_r, lobe_hw_nxt;
  logic [GUARD_W-1:0]  guard_r, guard_nxt;
  logic [FFT_W-1:0]    fft_len_r, fft_len_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [KW-1:0]       scan_k_r, scan_k_nxt;
  logic [KW-1:0]       scan_hi_r, scan_hi_nxt;
  logic                rd_v_r, rd_v_nxt;
  logic [KW-1:0]       rd_k_r, rd_k_nxt;
  logic [PWR_W-1:0]    pa_r, pa_nxt, pb_r, pb_nxt;
  logic [AW-1:0]       ka_r, ka_nxt, kb_r, kb_nxt;
  logic                fa_r, fa_nxt, fb_r, fb_nxt;
  logic [AW-1:0]       k1_r, k1_nxt, k2_r, k2_nxt;
  logic [2:0]          j_r, j_nxt;
  logic                fold_go_r, fold_go_nxt;
  logic [FOLD_W-1:0]   c_r, c_nxt;
  logic [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]    res_pow_r [NLOBE];
  logic [SUM_W-1:0]    res_pow_nxt [NLOBE];
  logic [BIN_W-1:0]    res_bin_r [NLOBE];
  logic [BIN_W-1:0]    res_bin_nxt [NLOBE];
  logic                ok_r, ok_nxt;
  logic                out_v_r, out_v_nxt;
  logic [OUT_DW-1:0]   out_d_r, out_d_nxt;
  logic                out_u_r, out_u_nxt;

  logic                ram_we;
  logic [PWR_W-1:0]    rd_data;
  logic [CW-1:0]       n_new;
  logic                scan_st, issue, scan_done;
  logic [KW-1:0]       ka_ext, peak_gap, lo_k, hi_raw, hi_k, n_top;
  logic [KW-1:0]       fold_ext, lhw_ext;
  logic [MW-1:0]       k1_2x, k2_2x, k1_ext, k2_ext;
  logic [MW-1:0]       dividend;
  logic [FFT_W-1:0]    n_eff;
  logic                in_acc;
  fold_res_t           fold_res;

  function automatic logic [BIN_W-1:0] clamp_bin(input logic [KW-1:0] v);
    clamp_bin = (v > KW'(BIN_MAX)) ? BIN_MAX : v[BIN_W-1:0];
  endfunction

  imd_ram #(.WIDTH(PWR_W), .DEPTH(MAX_BINS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (in_tdata),
    .raddr (scan_k_r[AW-1:0]),
    .rdata (rd_data)
  );

  imd_fold #(.MW(MW)) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fold_go_r),
    .dividend (dividend),
    .modulus  (n_eff),
    .res      (fold_res)
  );

  assign n_eff  = (fft_len_r < FFT_W'(2)) ? FFT_W'(2) : fft_len_r;
  assign k1_ext = MW'(k1_r);
  assign k2_ext = MW'(k2_r);
  assign k1_2x  = {k1_r, 1'b0};
  assign k2_2x  = {k2_r, 1'b0};

  always_comb begin
    case (j_r)
      3'd0:    dividend = k1_ext;
      3'd1:    dividend = k2_ext;
      3'd2:    dividend = (k1_2x >= k2_ext) ? (k1_2x - k2_ext) : (k2_ext - k1_2x);
      3'd3:    dividend = k2_2x - k1_ext;
      default: dividend = k2_ext - k1_ext;
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign scan_st   = (state_r == S_PEAK1) || (state_r == S_PEAK2) || (state_r == S_LOBE);
  assign issue     = scan_st && (scan_k_r <= scan_hi_r);
  assign scan_done = !issue && !rd_v_r;
  assign ka_ext    = KW'(ka_r);
  assign peak_gap  = (rd_k_r >= ka_ext) ? (rd_k_r - ka_ext) : (ka_ext - rd_k_r);
  assign n_top     = KW'(cnt_r) - 1'b1;

  // lobe window around the folded bin, clamped to the stored spectrum
  assign fold_ext = KW'(fold_res.value);
  assign lhw_ext  = KW'(lobe_hw_r);
  assign lo_k     = (fold_ext >= lhw_ext) ? (fold_ext - lhw_ext) : '0;
  assign hi_raw   = fold_ext + lhw_ext;
  assign hi_k     = (hi_raw > n_top) ? n_top : hi_raw;

  always_comb begin
    state_nxt   = state_r;
    lobe_hw_nxt = lobe_hw_r;
    guard_nxt   = guard_r;
    fft_len_nxt = fft_len_r;
    cnt_nxt     = cnt_r;
    scan_k_nxt  = scan_k_r;
    scan_hi_nxt = scan_hi_r;
    rd_v_nxt    = issue;
    rd_k_nxt    = rd_k_r;
    pa_nxt      = pa_r;
    ka_nxt      = ka_r;
    fa_nxt      = fa_r;
    pb_nxt      = pb_r;
    kb_nxt      = kb_r;
    fb_nxt      = fb_r;
    k1_nxt      = k1_r;
    k2_nxt      = k2_r;
    j_nxt       = j_r;
    fold_go_nxt = 1'b0;
    c_nxt       = c_r;
    acc_nxt     = acc_r;
    res_pow_nxt = res_pow_r;
    res_bin_nxt = res_bin_r;
    ok_nxt      = ok_r;
    out_v_nxt   = out_v_r && !out_tready;
    out_d_nxt   = out_d_r;
    out_u_nxt   = out_u_r;
    ram_we      = 1'b0;
    n_new       = (cnt_r < CW'(MAX_BINS)) ? (cnt_r + 1'b1) : cnt_r;

    if (cfg_we) begin
      case (cfg_addr)
        REG_LOBE_HW: lobe_hw_nxt = cfg_wdata[LHW_W-1:0];
        REG_GUARD:   guard_nxt   = cfg_wdata[GUARD_W-1:0];
        REG_FFT_LEN: fft_len_nxt = cfg_wdata[FFT_W-1:0];
        default: ;
      endcase
    end

    if (issue) begin
      scan_k_nxt = scan_k_r + 1'b1;
      rd_k_nxt   = scan_k_r;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          ram_we  = (cnt_r < CW'(MAX_BINS));
          cnt_nxt = n_new;
          if (in_tlast) begin
            scan_k_nxt  = KW'(guard_r) + 1'b1;
            scan_hi_nxt = KW'(n_new) - 1'b1;
            fa_nxt      = 1'b0;
            state_nxt   = S_PEAK1;
          end
        end
      end
      S_PEAK1: begin
        if (rd_v_r && (!fa_r || rd_data > pa_r)) begin
          pa_nxt = rd_data;
          ka_nxt = rd_k_r[AW-1:0];
          fa_nxt = 1'b1;
        end
        if (scan_done) begin
          if (!fa_r) begin
            ok_nxt    = 1'b0;
            state_nxt = S_OUT;
          end else begin
            scan_k_nxt  = KW'(guard_r) + 1'b1;
            scan_hi_nxt = n_top;
            fb_nxt      = 1'b0;
            state_nxt   = S_PEAK2;
          end
        end
      end
      S_PEAK2: begin
        if (rd_v_r && (peak_gap > KW'(guard_r)) && (!fb_r || rd_data > pb_r)) begin
          pb_nxt = rd_data;
          kb_nxt = rd_k_r[AW-1:0];
          fb_nxt = 1'b1;
        end
        if (scan_done) begin
          if (!fb_r) begin
            ok_nxt    = 1'b0;
            state_nxt = S_OUT;
          end else begin
            k1_nxt      = (ka_r < kb_r) ? ka_r : kb_r;
            k2_nxt      = (ka_r < kb_r) ? kb_r : ka_r;
            j_nxt       = 3'd0;
            ok_nxt      = 1'b1;
            fold_go_nxt = 1'b1;
            state_nxt   = S_FOLD;
          end
        end
      end
      S_FOLD: begin
        if (fold_res.done) begin
          c_nxt       = fold_res.value;
          scan_k_nxt  = lo_k;
          scan_hi_nxt = hi_k;
          acc_nxt     = '0;
          state_nxt   = S_LOBE;
        end
      end
      S_LOBE: begin
        if (rd_v_r) begin
          acc_nxt = acc_r + SUM_W'(rd_data);
        end
        if (scan_done) begin
          res_pow_nxt[j_r] = acc_r;
          case (j_r)
            3'd0:    res_bin_nxt[j_r] = clamp_bin(KW'(k1_r));
            3'd1:    res_bin_nxt[j_r] = clamp_bin(KW'(k2_r));
            default: res_bin_nxt[j_r] = clamp_bin(KW'(c_r));
          endcase
          if (j_r == 3'(NLOBE - 1)) begin
            state_nxt = S_OUT;
          end else begin
            j_nxt       = j_r + 1'b1;
            fold_go_nxt = 1'b1;
            state_nxt   = S_FOLD;
          end
        end
      end
      S_OUT: begin
        if (!out_v_r || out_tready) begin
          out_v_nxt = 1'b1;
          out_u_nxt = ok_r;
          if (ok_r) begin
            out_d_nxt = {1'b0,
                         res_pow_r[4], res_bin_r[4],
                         res_pow_r[3], res_bin_r[3],
                         res_pow_r[2], res_bin_r[2],
                         res_pow_r[1], res_pow_r[0],
                         res_bin_r[1], res_bin_r[0]};
          end else begin
            out_d_nxt = '0;
          end
          cnt_nxt   = '0;
          state_nxt = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      lobe_hw_r <= RST_LOBE_HW;
      guard_r   <= RST_GUARD;
      fft_len_r <= RST_FFT_LEN;
      cnt_r     <= '0;
      rd_v_r    <= 1'b0;
      fa_r      <= 1'b0;
      fb_r      <= 1'b0;
      ok_r      <= 1'b0;
      fold_go_r <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      lobe_hw_r <= lobe_hw_nxt;
      guard_r   <= guard_nxt;
      fft_len_r <= fft_len_nxt;
      cnt_r     <= cnt_nxt;
      rd_v_r    <= rd_v_nxt;
      fa_r      <= fa_nxt;
      fb_r      <= fb_nxt;
      ok_r      <= ok_nxt;
      fold_go_r <= fold_go_nxt;
      out_v_r   <= out_v_nxt;
    end
    scan_k_r  <= scan_k_nxt;
    scan_hi_r <= scan_hi_nxt;
    rd_k_r    <= rd_k_nxt;
    pa_r      <= pa_nxt;
    ka_r      <= ka_nxt;
    pb_r      <= pb_nxt;
    kb_r      <= kb_nxt;
    k1_r      <= k1_nxt;
    k2_r      <= k2_nxt;
    j_r       <= j_nxt;
    c_r       <= c_nxt;
    acc_r     <= acc_nxt;
    res_pow_r <= res_pow_nxt;
    res_bin_r <= res_bin_nxt;
    out_d_r   <= out_d_nxt;
    out_u_r   <= out_u_nxt;
  end

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tuser  = out_u_r;

endmodule

/* rtl/imd_ram.sv */
module imd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/imd_fold.sv */
// Bit-serial remainder by the fft length, then reflection into 0..n/2.
module imd_fold
  import imd_pkg::*;
#(
  parameter int MW = 13
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MW-1:0]     dividend,
  input  logic [FFT_W-1:0]  modulus,
  output fold_res_t         res
);

  localparam int CNW = $clog2(MW + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNW-1:0]    cnt_r, cnt_nxt;
  logic [MW-1:0]     q_r, q_nxt;
  logic [FFT_W-1:0]  rem_r, rem_nxt;
  logic [FOLD_W-1:0] val_r, val_nxt;

  logic [FFT_W:0]    trial;
  logic [FFT_W:0]    trial_sub;
  logic [FFT_W-1:0]  refl;

  always_comb begin
    trial     = {rem_r, q_r[MW-1]};
    trial_sub = trial - {1'b0, modulus};
    refl      = ({rem_r, 1'b0} <= {1'b0, modulus}) ? rem_r : (modulus - rem_r);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    val_nxt  = val_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNW'(MW);
      q_nxt    = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_nxt = (trial >= {1'b0, modulus}) ? trial_sub[FFT_W-1:0] : trial[FFT_W-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        val_nxt  = refl[FOLD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    val_r <= val_nxt;
  end

  assign res.done  = done_r;
  assign res.value = val_r;

endmodule

/* rtl/imd_chk.sv */
module imd_chk
  import imd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              in_tlast,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser
);

  // no result survives reset
  a_rst_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // the final bin of a spectrum starts analysis, so input stalls next cycle
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after final bin");

  // a spectrum without two tones reports all-zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("invalid result carries nonzero fields");

  // tones come out ordered
  a_tone_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[11:0] <= out_tdata[23:12])
    else $error("tone bins out of order");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind two_tone_imd_spectrum_analyzer imd_chk u_imd_chk (.*);

/* tb/sv/two_tone_imd_spectrum_analyzer_tb.sv */
module two_tone_imd_spectrum_analyzer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imd_pkg::*;

  localparam int STORE_BINS = DEF_MAX_BINS;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 60;
  localparam int STALL_LIMIT = 100000;
  localparam int HOLD_AFTER = 6;
  localparam int HOLD_CYCLES = 3000;
  localparam int CALM_START = 15000;
  localparam int CALM_END = 30000;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic             last;
  } bin_item_t;

  typedef struct packed {
    logic             valid;
    logic [BIN_W-1:0] lo_bin;
    logic [BIN_W-1:0] hi_bin;
    logic [SUM_W-1:0] lo_pwr;
    logic [SUM_W-1:0] hi_pwr;
    logic [BIN_W-1:0] im3l_bin;
    logic [SUM_W-1:0] im3l_pwr;
    logic [BIN_W-1:0] im3h_bin;
    logic [SUM_W-1:0] im3h_pwr;
    logic [BIN_W-1:0] im2_bin;
    logic [SUM_W-1:0] im2_pwr;
  } imd_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [PWR_W-1:0]  in_tdata;
  logic              in_tlast;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tuser;

  two_tone_imd_spectrum_analyzer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // predictor state
  logic [PWR_W-1:0] spec_mem [0:STORE_BINS-1];
  int               spec_cnt;
  longint           lobe_hw_r;
  longint           guard_r;
  longint           fft_len_r;

  bin_item_t   bin_q [$];
  imd_result_t exp_results [$];

  int          bins_queued;
  int          bins_taken;
  int          results_seen;
  int          mismatch_cnt;
  int          stall_cycles;
  int          hold_left;
  bit          hold_done;
  int unsigned cycle_no;
  logic        in_acc;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic bit idle_roll();
    if (cycle_no >= CALM_START && cycle_no < CALM_END)
      return 1'b0;
    return $urandom_range(0, 99) < 7;
  endfunction

  // reflect a product bin into 0..fft_length/2
  function automatic longint fold_product(longint k);
    longint n;
    longint g;
    n = (fft_len_r < 2) ? 2 : fft_len_r;
    g = (k < 0) ? -k : k;
    g = g % n;
    return (2 * g <= n) ? g : n - g;
  endfunction

  function automatic logic [SUM_W-1:0] lobe_power(longint c);
    longint lo;
    longint hi;
    logic [SUM_W-1:0] acc;
    lo = c - lobe_hw_r;
    hi = c + lobe_hw_r;
    acc = '0;
    if (lo < 0)
      lo = 0;
    if (hi > spec_cnt - 1)
      hi = spec_cnt - 1;
    for (longint k = lo; k <= hi; k++)
      acc += SUM_W'(spec_mem[k]);
    return acc;
  endfunction

  function automatic logic [BIN_W-1:0] bin_cap(longint b);
    if (b > longint'(BIN_MAX))
      return BIN_MAX;
    return b[BIN_W-1:0];
  endfunction

  function automatic imd_result_t analyze_spectrum();
    imd_result_t r;
    longint ka;
    longint kb;
    longint d;
    longint k1;
    longint k2;
    longint c;
    logic [PWR_W-1:0] pa;
    logic [PWR_W-1:0] pb;
    r = '0;
    ka = -1;
    kb = -1;
    pa = '0;
    pb = '0;
    for (longint k = guard_r + 1; k < spec_cnt; k++) begin
      if (ka < 0 || spec_mem[k] > pa) begin
        pa = spec_mem[k];
        ka = k;
      end
    end
    if (ka < 0)
      return r;
    for (longint k = guard_r + 1; k < spec_cnt; k++) begin
      d = (k > ka) ? k - ka : ka - k;
      if (d > guard_r && (kb < 0 || spec_mem[k] > pb)) begin
        pb = spec_mem[k];
        kb = k;
      end
    end
    if (kb < 0)
      return r;
    k1 = (ka < kb) ? ka : kb;
    k2 = (ka < kb) ? kb : ka;
    r.valid = 1'b1;
    r.lo_bin = bin_cap(k1);
    r.lo_pwr = lobe_power(fold_product(k1));
    r.hi_bin = bin_cap(k2);
    r.hi_pwr = lobe_power(fold_product(k2));
    c = fold_product(2 * k1 - k2);
    r.im3l_bin = bin_cap(c);
    r.im3l_pwr = lobe_power(c);
    c = fold_product(2 * k2 - k1);
    r.im3h_bin = bin_cap(c);
    r.im3h_pwr = lobe_power(c);
    c = fold_product(k2 - k1);
    r.im2_bin = bin_cap(c);
    r.im2_pwr = lobe_power(c);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_cnt++;
    end
  endtask

  // input and result monitor
  always @(posedge clk) begin : mon
    imd_result_t want;
    cycle_no <= cycle_no + 1;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        bins_taken++;
        if (spec_cnt < STORE_BINS) begin
          spec_mem[spec_cnt] = in_tdata;
          spec_cnt++;
        end
        if (in_tlast) begin
          exp_results.push_back(analyze_spectrum());
          spec_cnt = 0;
        end
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (exp_results.size() == 0) begin
          $display("%0t: unexpected result transaction, expected none, actual %0h",
                   $time, out_tdata);
          mismatch_cnt++;
        end else begin
          want = exp_results.pop_front();
          check_field("result_valid", 64'(want.valid), 64'(out_tuser));
          check_field("tone_low_bin", 64'(want.lo_bin), 64'(out_tdata[11:0]));
          check_field("tone_high_bin", 64'(want.hi_bin), 64'(out_tdata[23:12]));
          check_field("tone_low_power", 64'(want.lo_pwr), 64'(out_tdata[62:24]));
          check_field("tone_high_power", 64'(want.hi_pwr), 64'(out_tdata[101:63]));
          check_field("im3_low_bin", 64'(want.im3l_bin), 64'(out_tdata[113:102]));
          check_field("im3_low_power", 64'(want.im3l_pwr), 64'(out_tdata[152:114]));
          check_field("im3_high_bin", 64'(want.im3h_bin), 64'(out_tdata[164:153]));
          check_field("im3_high_power", 64'(want.im3h_pwr), 64'(out_tdata[203:165]));
          check_field("im2_bin", 64'(want.im2_bin), 64'(out_tdata[215:204]));
          check_field("im2_power", 64'(want.im2_pwr), 64'(out_tdata[254:216]));
          check_field("pad_bit", 64'd0, 64'(out_tdata[255]));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // bin driver
  always @(negedge clk) begin : drv
    bin_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // transaction still pending, hold it
    end else if (bin_q.size() > 0 && !idle_roll()) begin
      nxt = bin_q.pop_front();
      in_tvalid <= 1'b1;
      in_tdata <= nxt.power;
      in_tlast <= nxt.last;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result sink, with one long hold-off so the block backs up into its input
  always @(negedge clk) begin : rcv
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      out_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_tready <= !idle_roll();
    end
  end

  task automatic push_bin(logic [PWR_W-1:0] p, logic last);
    bin_item_t b;
    b.power = p;
    b.last = last;
    bin_q.push_back(b);
    bins_queued++;
  endtask

  task automatic cfg_put(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    case (addr)
      REG_LOBE_HW: lobe_hw_r = longint'(val[LHW_W-1:0]);
      REG_GUARD:   guard_r = longint'(val[GUARD_W-1:0]);
      REG_FFT_LEN: fft_len_r = longint'(val[FFT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_config(int lhw, int guard, int fft);
    cfg_put(REG_LOBE_HW, CFG_DW'(lhw));
    cfg_put(REG_GUARD, CFG_DW'(guard));
    cfg_put(REG_FFT_LEN, CFG_DW'(fft));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    do
      @(negedge clk);
    while (bins_taken != bins_queued || exp_results.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // noise floor plus two tones, or a flat or fully random spectrum
  task automatic queue_spectrum(int n);
    logic [PWR_W-1:0] pw [];
    logic [PWR_W-1:0] tone;
    int mode;
    int t1;
    int t2;
    pw = new[n];
    mode = $urandom_range(0, 9);
    tone = $urandom;
    for (int i = 0; i < n; i++)
      pw[i] = (mode == 0) ? $urandom : (mode == 1) ? tone : $urandom_range(0, 4095);
    if (mode >= 2) begin
      tone = $urandom | 32'h8000_0000;
      t1 = $urandom_range(0, n - 1);
      t2 = $urandom_range(0, n - 1);
      pw[t1] = tone;
      // equal tones exercise the first-maximum tie rule
      pw[t2] = (mode == 2) ? tone : tone - $urandom_range(1, 1 << 20);
    end
    for (int i = 0; i < n; i++)
      push_bin(pw[i], i == n - 1);
  endtask

  task automatic run_phase(int lhw, int guard, int fft, int nspec, int nlo, int nhi);
    set_config(lhw, guard, fft);
    repeat (nspec) queue_spectrum($urandom_range(nlo, nhi));
    wait_drained();
  endtask

  initial begin : stim
    int g;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    spec_cnt = 0;
    lobe_hw_r = longint'(RST_LOBE_HW);
    guard_r = longint'(RST_GUARD);
    fft_len_r = longint'(RST_FFT_LEN);
    bins_queued = 0;
    bins_taken = 0;
    results_seen = 0;
    mismatch_cnt = 0;
    stall_cycles = 0;
    hold_left = 0;
    hold_done = 1'b0;
    cycle_no = 0;
    in_acc = 1'b0;
    for (int i = 0; i < STORE_BINS; i++)
      spec_mem[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: single bin, no tone above the guard
    push_bin(32'hFFFF_FFFF, 1'b1);
    wait_drained();

    // write to a nonexistent register must change nothing
    cfg_put(REG_UNUSED, 14'h3FFF);
    set_config(1, 2, 16);
    // first tone but nothing beyond the guard from it
    for (int i = 0; i < 4; i++)
      push_bin((i == 3) ? 32'd5 : 32'd0, i == 3);
    // tones at 3 and 7: lower IM3 goes negative, upper IM3 reflects
    for (int i = 0; i < 8; i++)
      push_bin((i == 0 || i == 3) ? 32'hFFFF_FFFF : (i == 7) ? 32'h8000_0000 : 32'd0,
               i == 7);
    // flat spectrum: ties resolve to the first bin found
    for (int i = 0; i < 8; i++)
      push_bin(32'hFFFF_FFFF, i == 7);
    wait_drained();

    run_phase(0, 0, 2, 8, 1, 30);
    run_phase(63, 3, 8192, 8, 1, 60);
    g = $urandom_range(0, 20);
    run_phase($urandom_range(0, 63), g, 1, 6, 1, g + 40);
    run_phase(10, 255, 512, 1, 270, 270);
    run_phase(10, 255, 512, 1, 520, 520);
    cfg_put(REG_UNUSED, CFG_DW'($urandom_range(0, 16383)));
    g = $urandom_range(0, 12);
    run_phase($urandom_range(0, 63), g, 0, 6, 1, g + 40);
    repeat (2) begin
      g = $urandom_range(0, 12);
      run_phase($urandom_range(0, 63), g, $urandom_range(2, 8192), 6, 1, g + 40);
    end

    repeat (100) @(negedge clk);
    if (mismatch_cnt == 0 && exp_results.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

/* two_tone_imd_spectrum_analyzer.f */
rtl/imd_pkg.sv
rtl/imd_ram.sv
rtl/imd_fold.sv
rtl/two_tone_imd_spectrum_analyzer.sv
rtl/imd_chk.sv
tb/sv/two_tone_imd_spectrum_analyzer_tb.sv
